[design/gpve_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpve_pkg
// Shared types and constants of the grid peak/valley/extremes detector.
// ----------------------------------------------------------------------------
package gpve_pkg;

  // sample and report widths
  localparam int SAMPLE_W   = 16;
  localparam int REPORT_W   = 8;
  localparam int TOTAL_W    = 16;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // result queue between classifier and output sequencer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CfgRowCount    = 2'd0,
    CfgColumnCount = 2'd1
  } cfg_reg_e;

  // result kinds
  typedef enum logic [1:0] {
    KindPeak   = 2'd0,
    KindValley = 2'd1,
    KindMax    = 2'd2,
    KindMin    = 2'd3
  } kind_e;

  // which result of a queued entry is on the outputs
  typedef enum logic [1:0] {
    SelCls = 2'd0,
    SelMax = 2'd1,
    SelMin = 2'd2
  } sel_e;

  // all results caused by one sample
  typedef struct packed {
    logic                       cls_v;
    kind_e                      cls_kind;
    logic [REPORT_W-1:0]        cls_row;
    logic [REPORT_W-1:0]        cls_col;
    logic signed [SAMPLE_W-1:0] cls_value;
    logic                       ext_v;
    logic [REPORT_W-1:0]        max_row;
    logic [REPORT_W-1:0]        max_col;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [REPORT_W-1:0]        min_row;
    logic [REPORT_W-1:0]        min_col;
    logic signed [SAMPLE_W-1:0] min_value;
    logic [TOTAL_W-1:0]         peak_total;
  } bundle_t;

  // queue write port
  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } qpush_t;

endpackage

[design/gpve_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpve_front
// Accepts samples, tracks the raster position, keeps the line store and the
// 3x3 window, classifies interior cells and tracks the grid extremes.
// ----------------------------------------------------------------------------
module gpve_front #(
  parameter int MAX_DIM = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  logic signed [gpve_pkg::SAMPLE_W-1:0] elevation_i,
  output logic                                 full_o,
  input  logic                                 cfg_valid_i,
  input  logic [gpve_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gpve_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [gpve_pkg::QCNT_W-1:0]          q_count_i,
  output gpve_pkg::qpush_t                     q_push_o
);

  localparam int PW       = $clog2(MAX_DIM);
  localparam int CW       = (PW + 1 > gpve_pkg::CFG_DATA_W) ? PW + 1 : gpve_pkg::CFG_DATA_W;
  localparam int SW       = gpve_pkg::SAMPLE_W;
  localparam int TW       = gpve_pkg::TOTAL_W;
  localparam int RESETDIM = (MAX_DIM < 256) ? MAX_DIM : 256;

  // clamp a written dimension into 1..MAX_DIM and return it minus one
  function automatic logic [PW-1:0] dim_limit(logic [gpve_pkg::CFG_DATA_W-1:0] v);
    logic [CW-1:0] x;
    x = CW'(v);
    if (x == '0) begin
      x = CW'(1);
    end else if (x > CW'(MAX_DIM)) begin
      x = CW'(MAX_DIM);
    end
    return PW'(x - CW'(1));
  endfunction

  // position reported masked to eight bits
  function automatic logic [gpve_pkg::REPORT_W-1:0] to_byte(logic [PW-1:0] p);
    logic [PW+gpve_pkg::REPORT_W-1:0] x;
    x = {{gpve_pkg::REPORT_W{1'b0}}, p};
    return x[gpve_pkg::REPORT_W-1:0];
  endfunction

  logic          accept;
  logic          cfg_wr;
  logic [PW-1:0] lim_row_q, lim_col_q;
  logic [PW-1:0] row_q, row_d, col_q, col_d;

  // second stage
  logic                 b_valid_q;
  logic signed [SW-1:0] b_sample_q;
  logic [PW-1:0]        b_row_q, b_col_q;
  logic                 b_first_q, b_end_q, b_inner_q;
  logic [2*SW-1:0]      rd_q;

  logic [2*SW-1:0]      line_mem [MAX_DIM];

  logic signed [SW-1:0] win_q [9];
  logic signed [SW-1:0] win_d [9];

  logic signed [SW-1:0] max_val_q, max_val_d, min_val_q, min_val_d;
  logic [PW-1:0]        max_row_q, max_row_d, max_col_q, max_col_d;
  logic [PW-1:0]        min_row_q, min_row_d, min_col_q, min_col_d;
  logic [TW-1:0]        peaks_q, peaks_d, peaks_now;
  logic                 is_peak, is_valley;
  logic signed [SW-1:0] ctr;

  // flow control: leave room for the sample in the second stage
  assign full_o = (q_count_i + gpve_pkg::QCNT_W'(b_valid_q))
                  >= gpve_pkg::QCNT_W'(gpve_pkg::QUEUE_DEPTH);
  assign accept = push_i && !full_o;
  assign cfg_wr = cfg_valid_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_row_q <= PW'(RESETDIM - 1);
      lim_col_q <= PW'(RESETDIM - 1);
    end else if (cfg_wr) begin
      case (cfg_index_i)
        gpve_pkg::CfgRowCount:    lim_row_q <= dim_limit(cfg_data_i);
        gpve_pkg::CfgColumnCount: lim_col_q <= dim_limit(cfg_data_i);
        default: ;
      endcase
    end
  end

  // raster position of the next sample
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (col_q == lim_col_q) begin
        col_d = '0;
        row_d = (row_q == lim_row_q) ? '0 : row_q + PW'(1);
      end else begin
        col_d = col_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_wr && (cfg_index_i == gpve_pkg::CfgRowCount ||
                            cfg_index_i == gpve_pkg::CfgColumnCount)) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // second stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept;
    end
  end

  // second stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_sample_q <= elevation_i;
      b_row_q    <= row_q;
      b_col_q    <= col_q;
      b_first_q  <= (row_q == '0) && (col_q == '0);
      b_end_q    <= (col_q == lim_col_q) && (row_q == lim_row_q);
      b_inner_q  <= (row_q >= PW'(2)) && (col_q >= PW'(2));
    end
  end

  // line store: upper line in the high half, middle line in the low half
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[col_q];
    end
    if (b_valid_q) begin
      line_mem[b_col_q] <= {rd_q[SW-1:0], b_sample_q};
    end
  end

  // window shifts left, new column from the line store and the sample
  always_comb begin
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = rd_q[2*SW-1:SW];
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = rd_q[SW-1:0];
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = b_sample_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (b_valid_q) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // classify the center cell
  always_comb begin
    ctr     = win_d[4];
    is_peak = 1'b1;
    for (int i = 0; i < 9; i++) begin
      if (i != 4 && !(ctr > win_d[i])) begin
        is_peak = 1'b0;
      end
    end
    is_valley = (ctr < win_d[1]) && (ctr < win_d[3]) &&
                (ctr < win_d[5]) && (ctr < win_d[7]);
  end

  // peak count, saturating
  always_comb begin
    peaks_now = peaks_q;
    if (b_valid_q && b_inner_q && is_peak && peaks_q != {TW{1'b1}}) begin
      peaks_now = peaks_q + TW'(1);
    end
    peaks_d = (b_valid_q && b_end_q) ? '0 : peaks_now;
  end

  // running extremes, first sample of the grid loads both
  always_comb begin
    max_val_d = max_val_q;
    max_row_d = max_row_q;
    max_col_d = max_col_q;
    min_val_d = min_val_q;
    min_row_d = min_row_q;
    min_col_d = min_col_q;
    if (b_first_q) begin
      max_val_d = b_sample_q;
      max_row_d = b_row_q;
      max_col_d = b_col_q;
      min_val_d = b_sample_q;
      min_row_d = b_row_q;
      min_col_d = b_col_q;
    end else begin
      if (b_sample_q > max_val_q) begin
        max_val_d = b_sample_q;
        max_row_d = b_row_q;
        max_col_d = b_col_q;
      end
      if (b_sample_q < min_val_q) begin
        min_val_d = b_sample_q;
        min_row_d = b_row_q;
        min_col_d = b_col_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peaks_q   <= '0;
      max_val_q <= '0;
      max_row_q <= '0;
      max_col_q <= '0;
      min_val_q <= '0;
      min_row_q <= '0;
      min_col_q <= '0;
    end else if (cfg_wr && (cfg_index_i == gpve_pkg::CfgRowCount ||
                            cfg_index_i == gpve_pkg::CfgColumnCount)) begin
      peaks_q   <= '0;
      max_val_q <= '0;
      max_row_q <= '0;
      max_col_q <= '0;
      min_val_q <= '0;
      min_row_q <= '0;
      min_col_q <= '0;
    end else if (b_valid_q) begin
      peaks_q   <= peaks_d;
      max_val_q <= max_val_d;
      max_row_q <= max_row_d;
      max_col_q <= max_col_d;
      min_val_q <= min_val_d;
      min_row_q <= min_row_d;
      min_col_q <= min_col_d;
    end
  end

  // results of this sample toward the queue
  always_comb begin
    q_push_o.bundle.cls_v      = b_inner_q && (is_peak || is_valley);
    q_push_o.bundle.cls_kind   = is_peak ? gpve_pkg::KindPeak : gpve_pkg::KindValley;
    q_push_o.bundle.cls_row    = to_byte(b_row_q - PW'(1));
    q_push_o.bundle.cls_col    = to_byte(b_col_q - PW'(1));
    q_push_o.bundle.cls_value  = ctr;
    q_push_o.bundle.ext_v      = b_end_q;
    q_push_o.bundle.max_row    = to_byte(max_row_d);
    q_push_o.bundle.max_col    = to_byte(max_col_d);
    q_push_o.bundle.max_value  = max_val_d;
    q_push_o.bundle.min_row    = to_byte(min_row_d);
    q_push_o.bundle.min_col    = to_byte(min_col_d);
    q_push_o.bundle.min_value  = min_val_d;
    q_push_o.bundle.peak_total = peaks_now;
    q_push_o.valid = b_valid_q && (q_push_o.bundle.cls_v || q_push_o.bundle.ext_v);
  end

endmodule

[design/gpve_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpve_back
// Result queue; each entry holds all results of one sample, which are
// handed out one per transaction in order.
// ----------------------------------------------------------------------------
module gpve_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gpve_pkg::qpush_t                     q_push_i,
  output logic [gpve_pkg::QCNT_W-1:0]          q_count_o,
  input  logic                                 pop_i,
  output logic                                 empty_o,
  output logic [1:0]                           kind_o,
  output logic [gpve_pkg::REPORT_W-1:0]        row_o,
  output logic [gpve_pkg::REPORT_W-1:0]        column_o,
  output logic signed [gpve_pkg::SAMPLE_W-1:0] value_o,
  output logic [gpve_pkg::TOTAL_W-1:0]         peak_total_o,
  output logic                                 last_o
);

  localparam int QW = gpve_pkg::QPTR_W;
  localparam int CN = gpve_pkg::QCNT_W;

  gpve_pkg::bundle_t ent_q [gpve_pkg::QUEUE_DEPTH];
  gpve_pkg::bundle_t head;
  logic [QW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CN-1:0]     count_q;
  gpve_pkg::sel_e    sel_q, sel_d, sel_eff;
  logic              take, deq;

  assign head      = ent_q[rd_ptr_q];
  assign empty_o   = (count_q == '0);
  assign q_count_o = count_q;
  assign take      = pop_i && !empty_o;

  // first result of an entry without a classified cell is the maximum
  assign sel_eff = (sel_q == gpve_pkg::SelCls && !head.cls_v) ? gpve_pkg::SelMax : sel_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (q_push_i.valid) begin
      ent_q[wr_ptr_q] <= q_push_i.bundle;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (q_push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + QW'(1);
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + QW'(1);
      end
      count_q <= count_q + CN'(q_push_i.valid) - CN'(deq);
    end
  end

  // sequencer next state
  always_comb begin
    sel_d = sel_q;
    deq   = 1'b0;
    if (take) begin
      case (sel_eff)
        gpve_pkg::SelCls: begin
          if (head.ext_v) begin
            sel_d = gpve_pkg::SelMax;
          end else begin
            sel_d = gpve_pkg::SelCls;
            deq   = 1'b1;
          end
        end
        gpve_pkg::SelMax: begin
          sel_d = gpve_pkg::SelMin;
        end
        gpve_pkg::SelMin: begin
          sel_d = gpve_pkg::SelCls;
          deq   = 1'b1;
        end
        default: begin
          sel_d = gpve_pkg::SelCls;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= gpve_pkg::SelCls;
    end else begin
      sel_q <= sel_d;
    end
  end

  // sequencer outputs
  always_comb begin
    peak_total_o = head.peak_total;
    case (sel_eff)
      gpve_pkg::SelCls: begin
        kind_o   = head.cls_kind;
        row_o    = head.cls_row;
        column_o = head.cls_col;
        value_o  = head.cls_value;
        last_o   = !head.ext_v;
      end
      gpve_pkg::SelMax: begin
        kind_o   = gpve_pkg::KindMax;
        row_o    = head.max_row;
        column_o = head.max_col;
        value_o  = head.max_value;
        last_o   = 1'b0;
      end
      gpve_pkg::SelMin: begin
        kind_o   = gpve_pkg::KindMin;
        row_o    = head.min_row;
        column_o = head.min_col;
        value_o  = head.min_value;
        last_o   = 1'b1;
      end
      default: begin
        kind_o   = gpve_pkg::KindMin;
        row_o    = head.min_row;
        column_o = head.min_col;
        value_o  = head.min_value;
        last_o   = 1'b1;
      end
    endcase
  end

endmodule

[design/grid_peak_valley_extremes_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_peak_valley_extremes_top
// 3x3 local peak/valley detection on a raster grid, with grid extremes.
// ----------------------------------------------------------------------------
// Each sample is registered in a second stage, then its results are queued.
// Throughput: one sample per cycle while full is low; results leave one per cycle
// while popped; a grid end (up to three results) holds the four-entry queue longer.
// Reset: positions, extremes and peak count clear, both dimensions become
// 256 (capped at MAX_DIM); the line store is not cleared.
module grid_peak_valley_extremes_top #(
  parameter int MAX_DIM = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [gpve_pkg::SAMPLE_W-1:0] elevation_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [1:0]                           kind_o,
  output logic [gpve_pkg::REPORT_W-1:0]        row_o,
  output logic [gpve_pkg::REPORT_W-1:0]        column_o,
  output logic signed [gpve_pkg::SAMPLE_W-1:0] value_o,
  output logic [gpve_pkg::TOTAL_W-1:0]         peak_total_o,
  output logic                                 last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gpve_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gpve_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  gpve_pkg::qpush_t                q_push;
  logic [gpve_pkg::QCNT_W-1:0]     q_count;

  assign cfg_ready_o = 1'b1;

  // sample intake and classification
  gpve_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .elevation_i(elevation_i),
    .full_o     (full),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_count_i  (q_count),
    .q_push_o   (q_push)
  );

  // result queue and output sequencer
  gpve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_push_i    (q_push),
    .q_count_o   (q_count),
    .pop_i       (pop),
    .empty_o     (empty),
    .kind_o      (kind_o),
    .row_o       (row_o),
    .column_o    (column_o),
    .value_o     (value_o),
    .peak_total_o(peak_total_o),
    .last_o      (last_o)
  );

  // queue never written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push.valid |-> (q_count < gpve_pkg::QCNT_W'(gpve_pkg::QUEUE_DEPTH)))
    else $error("result queue overflow");

  // every queued entry carries at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push.valid |-> (q_push.bundle.cls_v || q_push.bundle.ext_v))
    else $error("empty entry queued");

  // minimum closes a sample's results, maximum never does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == gpve_pkg::KindMin) |-> last_o)
    else $error("minimum result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == gpve_pkg::KindMax) |-> !last_o)
    else $error("maximum result marked last");

endmodule

[dv/tb_grid_peak_valley_extremes_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_peak_valley_extremes_top
// Self-checking bench for the 3x3 peak/valley and grid extremes detector.
// Samples are driven over the push/full side. A behavioral copy of the line
// stores, window and running extremes predicts each report, and the monitor
// compares the popped reports in order. Directed grids come first, then one
// wide grid, then many small random grids under varying idling.
// ----------------------------------------------------------------------------
module tb_grid_peak_valley_extremes_top;

  localparam int SAMPLE_W   = gpve_pkg::SAMPLE_W;
  localparam int REPORT_W   = gpve_pkg::REPORT_W;
  localparam int TOTAL_W    = gpve_pkg::TOTAL_W;
  localparam int CFG_DATA_W = gpve_pkg::CFG_DATA_W;
  localparam int CFG_IDX_W  = gpve_pkg::CFG_IDX_W;

  localparam int                  LINE_LEN    = 256;
  localparam int                  QUIET_LIMIT = 4000;
  localparam int                  SETTLE_CYC  = 4;
  localparam int                  RANDOM_GOAL = 90;
  localparam int                  RANDOM_CAP  = 64;
  localparam logic [CFG_IDX_W-1:0] CfgSpareA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CfgSpareB  = 2'd3;

  typedef gpve_pkg::kind_e kind_e;
  typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_e;
  typedef enum int {ContentFull, ContentNarrow, ContentRails, ContentSpiky} content_e;

  typedef struct {
    kind_e                      kind;
    logic [REPORT_W-1:0]        row;
    logic [REPORT_W-1:0]        col;
    logic signed [SAMPLE_W-1:0] value;
    logic [TOTAL_W-1:0]         total;
    logic                       last;
  } report_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // block ports
  logic                       push = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] elevation_i = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [1:0]                 kind_o;
  logic [REPORT_W-1:0]        row_o;
  logic [REPORT_W-1:0]        column_o;
  logic signed [SAMPLE_W-1:0] value_o;
  logic [TOTAL_W-1:0]         peak_total_o;
  logic                       last_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;

  grid_peak_valley_extremes_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .elevation_i (elevation_i),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .row_o       (row_o),
    .column_o    (column_o),
    .value_o     (value_o),
    .peak_total_o(peak_total_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // bench state
  logic signed [SAMPLE_W-1:0] samples_to_send[$];
  report_t                    expected_reports[$];
  report_t                    front_report;
  int                         send_idle_pct = 0;
  int                         recv_stall_pct = 0;
  int                         mismatches = 0;
  int                         reports_checked = 0;
  int                         samples_taken = 0;
  int                         cfg_writes = 0;
  int                         quiet_cycles = 0;

  // predictor copy of the detector
  logic [CFG_DATA_W-1:0]      rows_setting = 9'd256;
  logic [CFG_DATA_W-1:0]      cols_setting = 9'd256;
  logic signed [SAMPLE_W-1:0] upper_store[LINE_LEN];
  logic signed [SAMPLE_W-1:0] middle_store[LINE_LEN];
  logic signed [SAMPLE_W-1:0] win[9] = '{default: '0};
  int unsigned                grid_row = 0;
  int unsigned                grid_col = 0;
  logic signed [SAMPLE_W-1:0] hi_val = '0;
  logic signed [SAMPLE_W-1:0] lo_val = '0;
  logic [REPORT_W-1:0]        hi_row = '0;
  logic [REPORT_W-1:0]        hi_col = '0;
  logic [REPORT_W-1:0]        lo_row = '0;
  logic [REPORT_W-1:0]        lo_col = '0;
  logic [TOTAL_W-1:0]         peak_tally = '0;
  int                         peaks_seen = 0;
  int                         valleys_seen = 0;
  int                         grids_done = 0;

  // register value to grid size: zero acts as one, capped at the line length
  function automatic int unsigned fit_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > LINE_LEN) return LINE_LEN;
    return 32'(v);
  endfunction

  function automatic report_t make_report(input kind_e k, input int unsigned r,
                                          input int unsigned c,
                                          input logic signed [SAMPLE_W-1:0] v);
    report_t rep;
    rep.kind  = k;
    rep.row   = r[REPORT_W-1:0];
    rep.col   = c[REPORT_W-1:0];
    rep.value = v;
    rep.total = peak_tally;
    rep.last  = 1'b0;
    return rep;
  endfunction

  task automatic restart_grid();
    grid_row   = 0;
    grid_col   = 0;
    hi_val     = '0;
    lo_val     = '0;
    hi_row     = '0;
    hi_col     = '0;
    lo_row     = '0;
    lo_col     = '0;
    peak_tally = '0;
  endtask

  // one accepted sample: update window and extremes, queue the reports it causes
  task automatic predict_reports(input logic signed [SAMPLE_W-1:0] s);
    int unsigned                rows;
    int unsigned                cols;
    int unsigned                r;
    int unsigned                c;
    int                         i;
    logic signed [SAMPLE_W-1:0] ctr;
    bit                         is_peak;
    report_t                    caused[$];
    rows = fit_dim(rows_setting);
    cols = fit_dim(cols_setting);
    r    = grid_row;
    c    = grid_col;

    // slide the window, newest column enters on the right
    for (i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2]          = upper_store[c];
    win[5]          = middle_store[c];
    win[8]          = s;
    upper_store[c]  = middle_store[c];
    middle_store[c] = s;

    // running extremes, first position wins on ties
    if (r == 0 && c == 0) begin
      hi_val = s;
      lo_val = s;
      hi_row = '0;
      hi_col = '0;
      lo_row = '0;
      lo_col = '0;
    end else begin
      if (s > hi_val) begin
        hi_val = s;
        hi_row = r[REPORT_W-1:0];
        hi_col = c[REPORT_W-1:0];
      end
      if (s < lo_val) begin
        lo_val = s;
        lo_row = r[REPORT_W-1:0];
        lo_col = c[REPORT_W-1:0];
      end
    end

    // classify the interior cell one row up, one column left
    if (r >= 2 && c >= 2) begin
      ctr     = win[4];
      is_peak = 1'b1;
      for (i = 0; i < 9; i++) begin
        if (i != 4 && !(ctr > win[i])) is_peak = 1'b0;
      end
      if (is_peak) begin
        if (peak_tally != '1) peak_tally++;
        caused.push_back(make_report(gpve_pkg::KindPeak, r - 1, c - 1, ctr));
        peaks_seen++;
      end else if (ctr < win[1] && ctr < win[3] && ctr < win[5] && ctr < win[7]) begin
        caused.push_back(make_report(gpve_pkg::KindValley, r - 1, c - 1, ctr));
        valleys_seen++;
      end
    end

    // advance; the last sample of the grid reports the extremes
    if (c + 1 >= cols) begin
      grid_col = 0;
      if (r + 1 >= rows) begin
        caused.push_back(make_report(gpve_pkg::KindMax, hi_row, hi_col, hi_val));
        caused.push_back(make_report(gpve_pkg::KindMin, lo_row, lo_col, lo_val));
        restart_grid();
        grids_done++;
      end else begin
        grid_row = r + 1;
      end
    end else begin
      grid_col = c + 1;
    end

    if (caused.size() > 0) caused[caused.size()-1].last = 1'b1;
    foreach (caused[k]) expected_reports.push_back(caused[k]);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push        <= 1'b0;
      elevation_i <= '0;
    end else begin
      if (push && !full) begin
        predict_reports(elevation_i);
        samples_taken++;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (samples_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push        <= 1'b1;
        elevation_i <= samples_to_send.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // report monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_reports.size() == 0) begin
          note_mismatch($sformatf("unexpected report kind %0d row %0d col %0d value %0d",
                                  kind_o, row_o, column_o, value_o));
        end else begin
          front_report = expected_reports.pop_front();
          reports_checked++;
          if (kind_o !== front_report.kind)
            note_mismatch($sformatf("kind got %0d want %0d",
                                    kind_o, front_report.kind));
          if (row_o !== front_report.row)
            note_mismatch($sformatf("row got %0d want %0d", row_o, front_report.row));
          if (column_o !== front_report.col)
            note_mismatch($sformatf("column got %0d want %0d",
                                    column_o, front_report.col));
          if (value_o !== front_report.value)
            note_mismatch($sformatf("value got %0d want %0d",
                                    value_o, front_report.value));
          if (peak_total_o !== front_report.total)
            note_mismatch($sformatf("peak_total got %0d want %0d",
                                    peak_total_o, front_report.total));
          if (last_o !== front_report.last)
            note_mismatch($sformatf("last got %0d want %0d", last_o, front_report.last));
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input idle_e m);
    case (m)
      IdleNone: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IdleSend: begin
        send_idle_pct  = 80;
        recv_stall_pct = 0;
      end
      IdleRecv: begin
        send_idle_pct  = 0;
        recv_stall_pct = 80;
      end
      default: begin
        send_idle_pct  = 19;
        recv_stall_pct = 19;
      end
    endcase
  endtask

  // wait until every sample is taken and every report has left, then let
  // the pipeline drain samples that caused no report
  task automatic settle(input int extra);
    do @(posedge clk_i);
    while (samples_to_send.size() > 0 || push || expected_reports.size() > 0);
    repeat (extra) @(posedge clk_i);
  endtask

  // one config transaction; the block must be idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    if (idx == gpve_pkg::CfgRowCount) begin
      rows_setting = data;
      restart_grid();
    end else if (idx == gpve_pkg::CfgColumnCount) begin
      cols_setting = data;
      restart_grid();
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned k;
    k = $urandom_range(15);
    if (k == 0) return 9'd0;
    if (k == 1) return 9'd1;
    if (k == 2) return 9'd2;
    if (k == 3) return 9'($urandom_range(257, 511));
    return 9'($urandom_range(3, 8));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input content_e style);
    logic [SAMPLE_W-1:0] raw;
    case (style)
      ContentFull:   raw = 16'($urandom());
      ContentNarrow: raw = 16'($urandom_range(4) - 2);
      ContentRails: begin
        case ($urandom_range(3))
          0:       raw = 16'h8000;
          1:       raw = 16'h7FFF;
          2:       raw = 16'h0000;
          default: raw = 16'hFFFF;
        endcase
      end
      default: begin
        if ($urandom_range(3) == 0) raw = 16'($urandom_range(1000, 32767));
        else                        raw = 16'($urandom_range(50) - 25);
      end
    endcase
    return raw;
  endfunction

  // stimulus
  initial begin
    int unsigned cells;
    int unsigned to_send;
    int          random_sent;
    int          grid_no;
    bit          must_write;
    content_e    style;
    report_t     left_over;
    logic signed [SAMPLE_W-1:0] peak_grid[9];
    logic signed [SAMPLE_W-1:0] valley_grid[9];
    peak_grid   = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF,
                    16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    valley_grid = '{16'sh8000, 16'sd5, 16'sh8000, 16'sd5, 16'sh8000,
                    16'sd5, 16'sh8000, 16'sd5, 16'sh8000};
    random_sent = 0;
    grid_no     = 0;
    must_write  = 1'b1;

    do @(posedge clk_i);
    while (!rst_ni);

    // directed: isolated peak at full scale, then a valley tied with its corners
    set_idling(IdleNone);
    write_register(gpve_pkg::CfgRowCount, 9'd3);
    write_register(gpve_pkg::CfgColumnCount, 9'd3);
    foreach (peak_grid[i]) samples_to_send.push_back(peak_grid[i]);
    foreach (valley_grid[i]) samples_to_send.push_back(valley_grid[i]);

    // directed: grid too small to classify
    settle(SETTLE_CYC);
    write_register(gpve_pkg::CfgRowCount, 9'd2);
    write_register(gpve_pkg::CfgColumnCount, 9'd2);
    samples_to_send.push_back(16'sh7FFF);
    samples_to_send.push_back(-16'sd1);
    samples_to_send.push_back(16'sh0000);
    samples_to_send.push_back(16'sh8000);

    // directed: zero dimensions act as one, spare indexes change nothing
    settle(SETTLE_CYC);
    write_register(gpve_pkg::CfgRowCount, 9'd0);
    write_register(gpve_pkg::CfgColumnCount, 9'd0);
    samples_to_send.push_back(-16'sd1);
    settle(SETTLE_CYC);
    write_register(CfgSpareA, 9'h1FF);
    write_register(CfgSpareB, 9'h000);
    samples_to_send.push_back(16'sh1234);

    // wide grid capped at the line length, minimum on the last column
    settle(SETTLE_CYC);
    set_idling(IdleBoth);
    write_register(gpve_pkg::CfgRowCount, 9'd1);
    write_register(gpve_pkg::CfgColumnCount, 9'h1FF);
    repeat (LINE_LEN - 1) samples_to_send.push_back(16'($urandom_range(65534) + 32769));
    samples_to_send.push_back(16'sh8000);

    // random small grids, some cut short, some back to back
    while (random_sent < RANDOM_GOAL) begin
      set_idling(idle_e'(grid_no % 4));
      if (must_write || $urandom_range(2) != 0) begin
        settle(SETTLE_CYC);
        if ($urandom_range(9) == 0) write_register(CfgSpareA, 9'($urandom()));
        write_register(gpve_pkg::CfgRowCount, pick_dim());
        write_register(gpve_pkg::CfgColumnCount, pick_dim());
      end
      cells   = fit_dim(rows_setting) * fit_dim(cols_setting);
      to_send = cells;
      if (cells > RANDOM_CAP) begin
        // keep random grids short: larger ones are rewritten to small dimensions
        settle(SETTLE_CYC);
        write_register(gpve_pkg::CfgRowCount, 9'($urandom_range(3, 6)));
        write_register(gpve_pkg::CfgColumnCount, 9'($urandom_range(3, 6)));
        cells   = fit_dim(rows_setting) * fit_dim(cols_setting);
        to_send = cells;
      end
      must_write = 1'b0;
      if (cells > 1 && $urandom_range(7) == 0) begin
        to_send    = $urandom_range(1, cells - 1);
        must_write = 1'b1;
      end
      style = content_e'($urandom_range(3));
      repeat (to_send) samples_to_send.push_back(pick_sample(style));
      random_sent += to_send;
      grid_no++;
    end

    // drain and close
    settle(4 * SETTLE_CYC);
    while (expected_reports.size() > 0) begin
      left_over = expected_reports.pop_front();
      note_mismatch($sformatf("report never seen: kind %0d row %0d col %0d",
                              left_over.kind, left_over.row, left_over.col));
    end
    $display("ran %0d samples over %0d complete grids with %0d register writes",
             samples_taken, grids_done, cfg_writes);
    $display("compared %0d reports: %0d peaks, %0d valleys, %0d mismatches",
             reports_checked, peaks_seen, valleys_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
design/gpve_pkg.sv
design/gpve_front.sv
design/gpve_back.sv
design/grid_peak_valley_extremes_top.sv
dv/tb_grid_peak_valley_extremes_top.sv
